>>> design/assert_macros.svh
// Assertion helpers used by the scanner unit. Each one samples on the
// rising edge of clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> design/flls_pkg.sv
package flls_pkg;

	localparam int MAX_LEN = 255;
	// The reported length is eight bits wide, so the bound never exceeds 255.
	localparam int LIMIT = (MAX_LEN < 255) ? MAX_LEN : 255;
	// Counters saturate one past the bound, which can be 256.
	localparam int CNT_W = 9;
	localparam int LEN_W = 8;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_E_LO  = 8'h65;
	localparam logic [7:0] CH_E_UP  = 8'h45;

	typedef enum logic [17:0] {
		PH_START = 18'h00001,
		PH_SIGN  = 18'h00002,
		PH_INT   = 18'h00004,
		PH_DOT0  = 18'h00008,
		PH_FRAC  = 18'h00010,
		PH_EXP0  = 18'h00020,
		PH_EXPS  = 18'h00040,
		PH_EXPD  = 18'h00080,
		PH_DONE  = 18'h00100,
		PH_INF1  = 18'h00200,
		PH_INF2  = 18'h00400,
		PH_INF3  = 18'h00800,
		PH_INF4  = 18'h01000,
		PH_INF5  = 18'h02000,
		PH_INF6  = 18'h04000,
		PH_INF7  = 18'h08000,
		PH_NAN1  = 18'h10000,
		PH_NAN2  = 18'h20000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_FINITE = 2'd1,
		KIND_INF    = 2'd2,
		KIND_NAN    = 2'd3
	} kind_t;

	typedef struct packed {
		phase_t             phase;
		logic [CNT_W-1:0]   count;
		logic [CNT_W-1:0]   acc_len;
		kind_t              acc_kind;
		logic               ovf;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:    PH_START,
		count:    '0,
		acc_len:  '0,
		acc_kind: KIND_NONE,
		ovf:      1'b0
	};

	// Only ASCII capitals fold to lower case.
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

endpackage

>>> design/float_literal_length_scanner_unit.sv
// Float literal length scanner.
// The input channel (in_valid/in_ready) takes one character per item, with
// is_last set on the final character of a text. For every item with is_last
// set, the output channel (out_valid/out_ready) gives one item: the length of
// the longest leading decimal floating-point literal (0 if none), its kind and
// a flag that is set when the literal ran past the length bound.
// An item is captured into an input register; from there the scan state
// advances and, for a last character, the result register loads as soon as
// it is free. The scan state machine advances one character per cycle, so
// the block sustains one item per cycle except while a last character
// waits for the result register to free.
// Reset empties the input and result registers and puts the scanner at the
// start of a text. The scan state also returns there after each last item.
// While the receiver stalls, characters that are not last keep flowing; a
// last character waits in the input register until the result register frees,
// and input is then held off.
`include "assert_macros.svh"

module float_literal_length_scanner_unit #(
	parameter int MAX_LEN = flls_pkg::MAX_LEN
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] prefix_length,
	output logic [1:0] literal_kind,
	output logic       too_long
);

	// The reported length is eight bits wide, so the bound never exceeds 255.
	localparam int LIMIT = (MAX_LEN < 255) ? MAX_LEN : 255;

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 last_s1;
	flls_pkg::state_t     state_q;
	flls_pkg::state_t     state_nxt;
	logic                 out_valid_q;
	logic [7:0]           length_q;
	logic [1:0]           kind_q;
	logic                 too_long_q;
	logic                 out_free;
	logic                 s1_go;
	logic                 in_take;

	assign out_free = !out_valid_q || out_ready;
	assign s1_go    = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || s1_go;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	flls_step #(
		.MAX_LEN (MAX_LEN)
	) u_step (
		.cur       (state_q),
		.char_code (char_s1),
		.nxt       (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flls_pkg::STATE_RESET;
		end else if (s1_go) begin
			state_q <= last_s1 ? flls_pkg::STATE_RESET : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			if (state_nxt.acc_len == '0) begin
				length_q   <= '0;
				kind_q     <= flls_pkg::KIND_NONE;
				too_long_q <= 1'b0;
			end else begin
				length_q   <= (state_nxt.acc_len > flls_pkg::CNT_W'(LIMIT)) ?
					flls_pkg::LEN_W'(LIMIT) : state_nxt.acc_len[flls_pkg::LEN_W-1:0];
				kind_q     <= state_nxt.acc_kind;
				too_long_q <= state_nxt.ovf;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign prefix_length = length_q;
	assign literal_kind  = kind_q;
	assign too_long      = too_long_q;

	`ASSERT_IMPLIES(a_none_zero, out_valid_q && kind_q == flls_pkg::KIND_NONE, length_q == '0, "invalid result with nonzero length")
	`ASSERT_IMPLIES(a_long_sat, out_valid_q && too_long_q, length_q == flls_pkg::LEN_W'(LIMIT), "overlong result not saturated")
	`ASSERT_ALWAYS(a_cnt_bound, state_q.count <= flls_pkg::CNT_W'(LIMIT + 1), "character count past saturation")
	`ASSERT_ALWAYS(a_acc_le_cnt, state_q.acc_len <= state_q.count, "accepted length exceeds count")

endmodule

>>> design/flls_step.sv
module flls_step #(
	parameter int MAX_LEN = flls_pkg::MAX_LEN
) (
	input  flls_pkg::state_t   cur,
	input  logic [7:0]         char_code,
	output flls_pkg::state_t   nxt
);

	// The reported length is eight bits wide, so the bound never exceeds 255.
	localparam int LIMIT = (MAX_LEN < 255) ? MAX_LEN : 255;

	logic [7:0]                   low;
	logic                         dig;
	logic                         is_e;
	logic [flls_pkg::CNT_W-1:0]   cnt_inc;
	logic                         take;
	flls_pkg::kind_t              take_kind;
	flls_pkg::phase_t             ph_body;
	logic                         take_body;

	assign low  = flls_pkg::fold_case(char_code);
	assign is_e = (char_code == flls_pkg::CH_E_LO) || (char_code == flls_pkg::CH_E_UP);

	always_comb begin
		case (char_code) inside
			[8'h30:8'h39]: dig = 1'b1;
			default:       dig = 1'b0;
		endcase
	end

	// The count saturates one past the bound.
	assign cnt_inc = (cur.count <= flls_pkg::CNT_W'(LIMIT)) ?
		cur.count + flls_pkg::CNT_W'(1) : cur.count;

	// First character of the body, after an optional minus sign.
	always_comb begin
		take_body = 1'b0;
		if (low == "i") begin
			ph_body = flls_pkg::PH_INF1;
		end else if (low == "n") begin
			ph_body = flls_pkg::PH_NAN1;
		end else if (dig) begin
			ph_body   = flls_pkg::PH_INT;
			take_body = 1'b1;
		end else if (char_code == flls_pkg::CH_DOT) begin
			ph_body = flls_pkg::PH_DOT0;
		end else begin
			ph_body = flls_pkg::PH_DONE;
		end
	end

	always_comb begin
		take      = 1'b0;
		take_kind = flls_pkg::KIND_FINITE;
		nxt       = cur;
		nxt.phase = flls_pkg::PH_DONE;
		case (cur.phase)
			flls_pkg::PH_START: begin
				if (char_code == flls_pkg::CH_MINUS) begin
					nxt.phase = flls_pkg::PH_SIGN;
				end else begin
					nxt.phase = ph_body;
					take      = take_body;
				end
			end
			flls_pkg::PH_SIGN: begin
				nxt.phase = ph_body;
				take      = take_body;
			end
			flls_pkg::PH_INT: begin
				if (dig) begin
					nxt.phase = flls_pkg::PH_INT;
					take      = 1'b1;
				end else if (char_code == flls_pkg::CH_DOT) begin
					nxt.phase = flls_pkg::PH_FRAC;
					take      = 1'b1;
				end else if (is_e) begin
					nxt.phase = flls_pkg::PH_EXP0;
				end
			end
			flls_pkg::PH_DOT0: begin
				if (dig) begin
					nxt.phase = flls_pkg::PH_FRAC;
					take      = 1'b1;
				end
			end
			flls_pkg::PH_FRAC: begin
				if (dig) begin
					nxt.phase = flls_pkg::PH_FRAC;
					take      = 1'b1;
				end else if (is_e) begin
					nxt.phase = flls_pkg::PH_EXP0;
				end
			end
			flls_pkg::PH_EXP0: begin
				if (char_code == flls_pkg::CH_PLUS || char_code == flls_pkg::CH_MINUS) begin
					nxt.phase = flls_pkg::PH_EXPS;
				end else if (dig) begin
					nxt.phase = flls_pkg::PH_EXPD;
					take      = 1'b1;
				end
			end
			flls_pkg::PH_EXPS, flls_pkg::PH_EXPD: begin
				if (dig) begin
					nxt.phase = flls_pkg::PH_EXPD;
					take      = 1'b1;
				end
			end
			flls_pkg::PH_INF1: if (low == "n") nxt.phase = flls_pkg::PH_INF2;
			flls_pkg::PH_INF2: begin
				if (low == "f") begin
					nxt.phase = flls_pkg::PH_INF3;
					take      = 1'b1;
					take_kind = flls_pkg::KIND_INF;
				end
			end
			flls_pkg::PH_INF3: if (low == "i") nxt.phase = flls_pkg::PH_INF4;
			flls_pkg::PH_INF4: if (low == "n") nxt.phase = flls_pkg::PH_INF5;
			flls_pkg::PH_INF5: if (low == "i") nxt.phase = flls_pkg::PH_INF6;
			flls_pkg::PH_INF6: if (low == "t") nxt.phase = flls_pkg::PH_INF7;
			flls_pkg::PH_INF7: begin
				if (low == "y") begin
					take      = 1'b1;
					take_kind = flls_pkg::KIND_INF;
				end
			end
			flls_pkg::PH_NAN1: if (low == "a") nxt.phase = flls_pkg::PH_NAN2;
			flls_pkg::PH_NAN2: begin
				if (low == "n") begin
					take      = 1'b1;
					take_kind = flls_pkg::KIND_NAN;
				end
			end
			default: nxt.phase = flls_pkg::PH_DONE;
		endcase

		// Once the scan is over, nothing but is_last matters.
		if (cur.phase == flls_pkg::PH_DONE) begin
			nxt = cur;
		end else begin
			nxt.count = cnt_inc;
			if (take) begin
				nxt.acc_len  = cnt_inc;
				nxt.acc_kind = take_kind;
				nxt.ovf      = (cnt_inc > flls_pkg::CNT_W'(LIMIT));
			end
		end
	end

endmodule
